>>> design/lsap_pkg.sv
// ----------------------------------------------------------------------------
// Link supervisor package
// Shared types and constants for the link supervisor with portal fallback.
// ----------------------------------------------------------------------------
`default_nettype none

package lsap_pkg;

    // Supervisor modes, encoded as they appear on the result port.
    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_CONNECTING = 2'd1,
        MODE_CONNECTED  = 2'd2,
        MODE_PORTAL     = 2'd3
    } t_mode;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_CREDS = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam int unsigned AddrWidth = 5;
    localparam int unsigned IdxWidth  = 3;
    typedef enum logic [IdxWidth-1:0] {
        REG_CONNECT_TIMEOUT = 3'd0,
        REG_OFFLINE_TIMEOUT = 3'd1,
        REG_RETRY_INTERVAL  = 3'd2,
        REG_FALLBACK_EN     = 3'd3,
        REG_AUTO_RETRY_EN   = 3'd4
    } t_reg_idx;

    // Register reset values.
    localparam logic [31:0] ConnectTimeoutRst = 32'd10000;
    localparam logic [31:0] OfflineTimeoutRst = 32'd30000;
    localparam logic [31:0] RetryIntervalRst  = 32'd60000;
    localparam logic        FallbackEnRst     = 1'b1;
    localparam logic        AutoRetryEnRst    = 1'b1;

    // Configuration seen by the supervisor core.
    typedef struct packed {
        logic [31:0] connect_timeout_ms;
        logic [31:0] offline_timeout_ms;
        logic [31:0] retry_interval_ms;
        logic        fallback_enable;
        logic        auto_retry_enable;
    } t_cfg;

    // One result: mode after the step and the action strobes.
    typedef struct packed {
        t_mode mode_now;
        logic  is_connected;
        logic  start_station;
        logic  start_portal;
        logic  teardown_portal;
        logic  start_combined_retry;
        logic  drop_to_portal_only;
    } t_result;

endpackage

`default_nettype wire

>>> design/lsap_cfg.sv
// ----------------------------------------------------------------------------
// Link supervisor configuration registers
// APB-style register file holding the timeouts and the enable bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lsap_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lsap_pkg::AddrWidth-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output lsap_pkg::t_cfg                      o_cfg
);

    lsap_pkg::t_cfg                 r_cfg;
    logic                           wr_en;
    logic [lsap_pkg::IdxWidth-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[lsap_pkg::AddrWidth-1:2];
    assign o_cfg   = r_cfg;

    // Register writes on the access phase of a write request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.connect_timeout_ms <= lsap_pkg::ConnectTimeoutRst;
            r_cfg.offline_timeout_ms <= lsap_pkg::OfflineTimeoutRst;
            r_cfg.retry_interval_ms  <= lsap_pkg::RetryIntervalRst;
            r_cfg.fallback_enable    <= lsap_pkg::FallbackEnRst;
            r_cfg.auto_retry_enable  <= lsap_pkg::AutoRetryEnRst;
        end else if (wr_en) begin
            case (reg_idx)
                lsap_pkg::REG_CONNECT_TIMEOUT: r_cfg.connect_timeout_ms <= pwdata;
                lsap_pkg::REG_OFFLINE_TIMEOUT: r_cfg.offline_timeout_ms <= pwdata;
                lsap_pkg::REG_RETRY_INTERVAL:  r_cfg.retry_interval_ms  <= pwdata;
                lsap_pkg::REG_FALLBACK_EN:     r_cfg.fallback_enable    <= pwdata[0];
                lsap_pkg::REG_AUTO_RETRY_EN:   r_cfg.auto_retry_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read data mux; unused addresses read as zero.
    always_comb begin
        case (reg_idx)
            lsap_pkg::REG_CONNECT_TIMEOUT: prdata = r_cfg.connect_timeout_ms;
            lsap_pkg::REG_OFFLINE_TIMEOUT: prdata = r_cfg.offline_timeout_ms;
            lsap_pkg::REG_RETRY_INTERVAL:  prdata = r_cfg.retry_interval_ms;
            lsap_pkg::REG_FALLBACK_EN:     prdata = {31'd0, r_cfg.fallback_enable};
            lsap_pkg::REG_AUTO_RETRY_EN:   prdata = {31'd0, r_cfg.auto_retry_enable};
            default:                       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/lsap_core.sv
// ----------------------------------------------------------------------------
// Link supervisor core
// Holds the mode and timestamps and computes one step per accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module lsap_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lsap_pkg::t_cfg i_cfg,
    input  wire logic           i_step,
    input  wire lsap_pkg::t_op  i_op,
    input  wire logic [31:0]    i_now_ms,
    input  wire logic           i_link_up,
    input  wire logic           i_creds_valid,
    output lsap_pkg::t_result   o_res
);

    lsap_pkg::t_mode r_mode, n_mode;
    logic            r_have_creds, n_have_creds;
    logic [31:0]     r_connect_started_at, n_connect_started_at;
    logic [31:0]     r_offline_since, n_offline_since;
    logic [31:0]     r_last_retry_at, n_last_retry_at;
    logic [31:0]     r_combined_started_at, n_combined_started_at;

    logic st_station, st_portal, st_teardown, st_retry, st_drop;

    // Next state and strobes for the request being processed.
    always_comb begin
        n_mode                = r_mode;
        n_have_creds          = r_have_creds;
        n_connect_started_at  = r_connect_started_at;
        n_offline_since       = r_offline_since;
        n_last_retry_at       = r_last_retry_at;
        n_combined_started_at = r_combined_started_at;
        st_station  = 1'b0;
        st_portal   = 1'b0;
        st_teardown = 1'b0;
        st_retry    = 1'b0;
        st_drop     = 1'b0;

        case (i_op)
            lsap_pkg::OP_TICK: begin
                if (r_mode != lsap_pkg::MODE_IDLE) begin
                    // The link coming up moves any running mode to connected.
                    if (i_link_up && r_mode != lsap_pkg::MODE_CONNECTED) begin
                        st_teardown     = (r_mode == lsap_pkg::MODE_PORTAL);
                        n_mode          = lsap_pkg::MODE_CONNECTED;
                        n_offline_since = 32'd0;
                    end
                    case (n_mode)
                        lsap_pkg::MODE_CONNECTING: begin
                            if (!i_link_up && i_cfg.fallback_enable &&
                                (i_now_ms - r_connect_started_at) >=
                                i_cfg.connect_timeout_ms) begin
                                n_mode                = lsap_pkg::MODE_PORTAL;
                                n_combined_started_at = 32'd0;
                                st_portal             = 1'b1;
                            end
                        end
                        lsap_pkg::MODE_CONNECTED: begin
                            if (!i_link_up) begin
                                // A zero stamp means the offline timer is stopped.
                                if (r_offline_since == 32'd0) begin
                                    n_offline_since = i_now_ms;
                                end else if (i_cfg.fallback_enable &&
                                             (i_now_ms - r_offline_since) >=
                                             i_cfg.offline_timeout_ms) begin
                                    n_mode                = lsap_pkg::MODE_PORTAL;
                                    n_combined_started_at = 32'd0;
                                    st_portal             = 1'b1;
                                end
                            end else begin
                                n_offline_since = 32'd0;
                            end
                        end
                        lsap_pkg::MODE_PORTAL: begin
                            // Periodic station retry in combined mode.
                            if (i_cfg.auto_retry_enable && r_have_creds &&
                                (i_now_ms - r_last_retry_at) >=
                                i_cfg.retry_interval_ms) begin
                                n_last_retry_at       = i_now_ms;
                                n_combined_started_at = i_now_ms;
                                st_retry              = 1'b1;
                            end
                            // Combined mode times out back to portal only.
                            if (n_combined_started_at != 32'd0 && !i_link_up &&
                                (i_now_ms - n_combined_started_at) >=
                                i_cfg.connect_timeout_ms) begin
                                n_combined_started_at = 32'd0;
                                st_drop               = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            lsap_pkg::OP_BEGIN: begin
                n_have_creds = i_creds_valid;
                if (i_creds_valid) begin
                    n_mode                = lsap_pkg::MODE_CONNECTING;
                    n_connect_started_at  = i_now_ms;
                    n_last_retry_at       = i_now_ms;
                    n_combined_started_at = 32'd0;
                    st_station            = 1'b1;
                end else begin
                    n_mode                = lsap_pkg::MODE_PORTAL;
                    n_combined_started_at = 32'd0;
                    st_portal             = 1'b1;
                end
            end
            lsap_pkg::OP_CREDS: begin
                // Saved credentials only matter while the portal is up.
                if (r_mode == lsap_pkg::MODE_PORTAL) begin
                    n_have_creds          = 1'b1;
                    n_mode                = lsap_pkg::MODE_CONNECTING;
                    n_connect_started_at  = i_now_ms;
                    n_last_retry_at       = i_now_ms;
                    n_combined_started_at = 32'd0;
                    st_station            = 1'b1;
                end
            end
            default: begin
                n_mode                = lsap_pkg::MODE_IDLE;
                n_connect_started_at  = 32'd0;
                n_offline_since       = 32'd0;
                n_last_retry_at       = 32'd0;
                n_combined_started_at = 32'd0;
            end
        endcase
    end

    // Result of the step.
    always_comb begin
        o_res.mode_now             = n_mode;
        o_res.is_connected         = (n_mode == lsap_pkg::MODE_CONNECTED);
        o_res.start_station        = st_station;
        o_res.start_portal         = st_portal;
        o_res.teardown_portal      = st_teardown;
        o_res.start_combined_retry = st_retry;
        o_res.drop_to_portal_only  = st_drop;
    end

    // State update, once per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode                <= lsap_pkg::MODE_IDLE;
            r_have_creds          <= 1'b0;
            r_connect_started_at  <= 32'd0;
            r_offline_since       <= 32'd0;
            r_last_retry_at       <= 32'd0;
            r_combined_started_at <= 32'd0;
        end else if (i_step) begin
            r_mode                <= n_mode;
            r_have_creds          <= n_have_creds;
            r_connect_started_at  <= n_connect_started_at;
            r_offline_since       <= n_offline_since;
            r_last_retry_at       <= n_last_retry_at;
            r_combined_started_at <= n_combined_started_at;
        end
    end

    // A stop clears the mode and every timestamp.
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_op == lsap_pkg::OP_STOP |=>
            r_mode == lsap_pkg::MODE_IDLE && r_offline_since == 32'd0 &&
            r_last_retry_at == 32'd0 && r_combined_started_at == 32'd0)
        else $error("stop did not clear the supervisor state");

    // A station start records the request time and enters connecting.
    a_station_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.start_station |=>
            r_mode == lsap_pkg::MODE_CONNECTING &&
            r_connect_started_at == $past(i_now_ms) &&
            r_combined_started_at == 32'd0)
        else $error("station start left inconsistent state");

    // A portal teardown always lands in connected.
    a_teardown_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.teardown_portal |=> r_mode == lsap_pkg::MODE_CONNECTED)
        else $error("portal teardown without entering connected");

    // Station start and portal start never happen in one step.
    a_start_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(o_res.start_station && o_res.start_portal))
        else $error("station and portal started together");

endmodule

`default_nettype wire

>>> design/link_supervisor_with_ap_fallback_top.sv
// ----------------------------------------------------------------------------
// Link supervisor with access point fallback, top level
// Request register, supervisor core, result register and configuration port.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the result side is not
// stalled, and gives one result per request: the request is captured in an
// input register, the supervisor step is evaluated in combinational logic
// (four 32-bit wrapping subtract-and-compare paths and the mode update), and
// the result is loaded into an output register when the held request is
// processed, which waits while an earlier result is still held, and is held
// there until it is taken. Requests keep flowing while a result waits, up to
// the depth of the two registers. Configuration registers are written through
// the APB-style port and should only be changed while no request is in flight.
`default_nettype none

module link_supervisor_with_ap_fallback_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Request channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_op,
    input  wire logic [31:0]                    i_now_ms,
    input  wire logic                           i_link_up,
    input  wire logic                           i_creds_valid,
    // Result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_mode_now,
    output logic                                o_is_connected,
    output logic                                o_start_station,
    output logic                                o_start_portal,
    output logic                                o_teardown_portal,
    output logic                                o_start_combined_retry,
    output logic                                o_drop_to_portal_only,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lsap_pkg::AddrWidth-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    lsap_pkg::t_cfg    cfg;
    lsap_pkg::t_result step_res;
    lsap_pkg::t_result r_res;

    logic          r_in_vld;
    lsap_pkg::t_op r_op;
    logic [31:0]   r_now_ms;
    logic          r_link_up;
    logic          r_creds_valid;
    logic          r_out_vld;
    logic          step;
    logic          in_acc;

    // A held request is processed when the result register is free or draining.
    assign step       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || step;
    assign in_acc     = i_in_valid && o_in_ready;

    // Configuration registers.
    lsap_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Request register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    // Request register payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op          <= lsap_pkg::t_op'(i_op);
            r_now_ms      <= i_now_ms;
            r_link_up     <= i_link_up;
            r_creds_valid <= i_creds_valid;
        end
    end

    // Supervisor step.
    lsap_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_step        (step),
        .i_op          (r_op),
        .i_now_ms      (r_now_ms),
        .i_link_up     (r_link_up),
        .i_creds_valid (r_creds_valid),
        .o_res         (step_res)
    );

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid            = r_out_vld;
    assign o_mode_now             = r_res.mode_now;
    assign o_is_connected         = r_res.is_connected;
    assign o_start_station        = r_res.start_station;
    assign o_start_portal         = r_res.start_portal;
    assign o_teardown_portal      = r_res.teardown_portal;
    assign o_start_combined_retry = r_res.start_combined_retry;
    assign o_drop_to_portal_only  = r_res.drop_to_portal_only;

    // A waiting result is never dropped.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready |=> r_out_vld && $stable(r_res))
        else $error("waiting result lost or changed");

    // A held request is never overwritten before it is processed.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !step |=> r_in_vld && $stable(r_now_ms) && $stable(r_op))
        else $error("held request overwritten");

    // Each processed request leaves a valid result behind.
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_vld)
        else $error("processed request produced no result");

endmodule

`default_nettype wire
